// ----- rtl/core/swmma_pkg.sv -----
package swmma_pkg;

	localparam int WINDOW = 16;
	localparam int DATA_W = 24;
	localparam int PTR_W  = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = DATA_W + $clog2(WINDOW);
	localparam int STEP_W = $clog2(SUM_W + 1);

	typedef struct packed {
		logic signed [DATA_W-1:0] sample;
		logic                     last_of_series;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] average;
		logic signed [DATA_W-1:0] maximum;
		logic signed [DATA_W-1:0] minimum;
	} rsp_t;

endpackage

// ----- rtl/core/swmma_ram.sv -----
module swmma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/sliding_window_min_max_average.sv -----
// Channel   Direction  Handshake             Payload
// request   in         req_valid/req_ready   req (sample, last_of_series)
// result    out        rsp_valid/rsp_ready   rsp (average, maximum, minimum)
//
// One request at a time: after the accept edge the oldest sample is dropped when the
// window is full, the new sample is inserted, the held samples are scanned through the
// RAM read port, a restoring divide runs at one quotient bit a cycle, and the result
// is loaded into the result register. Reset empties the window and clears the result
// valid.
// A result waiting in the output register blocks only the final load, not accept.
module sliding_window_min_max_average (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  swmma_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output swmma_pkg::rsp_t   rsp
);

	localparam int WINDOW = swmma_pkg::WINDOW;
	localparam int DATA_W = swmma_pkg::DATA_W;
	localparam int PTR_W  = swmma_pkg::PTR_W;
	localparam int CNT_W  = swmma_pkg::CNT_W;
	localparam int SUM_W  = swmma_pkg::SUM_W;
	localparam int STEP_W = swmma_pkg::STEP_W;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DROP   = 6'b000010,
		ST_INSERT = 6'b000100,
		ST_SCAN   = 6'b001000,
		ST_DIV    = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t                   state_q;
	logic [PTR_W-1:0]         ptr_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         idx_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     rd_vld_s1;
	logic [STEP_W-1:0]        step_q;
	logic                     rsp_valid_q;

	swmma_pkg::req_t          req_q;
	swmma_pkg::rsp_t          rsp_q;
	logic signed [DATA_W-1:0] hi_q;
	logic signed [DATA_W-1:0] lo_q;
	logic [SUM_W-1:0]         quo_q;
	logic [CNT_W-1:0]         rem_q;
	logic                     neg_q;

	logic                     ram_we;
	logic [PTR_W-1:0]         ram_waddr;
	logic [PTR_W-1:0]         ram_raddr;
	logic [DATA_W-1:0]        ram_rdata;
	logic signed [DATA_W-1:0] rd_sample;

	logic                     scan_issue;
	logic                     rsp_load;
	logic [CNT_W:0]           trial_shift;
	logic [CNT_W:0]           trial_diff;
	logic                     trial_fits;
	logic [SUM_W-1:0]         sum_mag;
	logic [SUM_W-1:0]         avg_full;

	function automatic logic [PTR_W-1:0] wrap_add(logic [PTR_W-1:0] a, logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
		if (s >= (CNT_W+1)'(WINDOW)) begin
			s = s - (CNT_W+1)'(WINDOW);
		end
		return s[PTR_W-1:0];
	endfunction

	function automatic logic signed [SUM_W-1:0] sext(logic [DATA_W-1:0] v);
		return {{(SUM_W-DATA_W){v[DATA_W-1]}}, v};
	endfunction

	swmma_ram #(
		.WIDTH(DATA_W),
		.DEPTH(WINDOW)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req_q.sample),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_sample  = $signed(ram_rdata);
	assign ram_we     = (state_q == ST_INSERT);
	assign ram_waddr  = wrap_add(ptr_q, cnt_q);
	assign ram_raddr  = (state_q == ST_SCAN) ? wrap_add(ptr_q, idx_q) : ptr_q;
	assign scan_issue = (state_q == ST_SCAN) && (idx_q < cnt_q);

	assign req_ready  = (state_q == ST_IDLE);
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;
	assign rsp_load   = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);

	// one restoring divide step on the magnitude of the sum
	assign trial_shift = {rem_q, quo_q[SUM_W-1]};
	assign trial_diff  = trial_shift - {1'b0, cnt_q};
	assign trial_fits  = (trial_shift >= {1'b0, cnt_q});

	assign sum_mag  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign avg_full = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			sum_q       <= '0;
			rd_vld_s1   <= 1'b0;
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= (cnt_q == CNT_W'(WINDOW)) ? ST_DROP : ST_INSERT;
					end
				end
				ST_DROP: begin
					// oldest sample was read in the accept cycle
					sum_q   <= sum_q - sext(ram_rdata);
					ptr_q   <= (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + PTR_W'(1);
					cnt_q   <= CNT_W'(WINDOW - 1);
					state_q <= ST_INSERT;
				end
				ST_INSERT: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					sum_q   <= sum_q + sext(req_q.sample);
					idx_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					rd_vld_s1 <= scan_issue;
					if (scan_issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (!scan_issue && !rd_vld_s1) begin
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(SUM_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_load) begin
						if (req_q.last_of_series) begin
							cnt_q <= '0;
							ptr_q <= '0;
							sum_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					req_q <= req;
				end
			end
			ST_INSERT: begin
				hi_q <= req_q.sample;
				lo_q <= req_q.sample;
			end
			ST_SCAN: begin
				if (rd_vld_s1) begin
					if (rd_sample > hi_q) begin
						hi_q <= rd_sample;
					end
					if (rd_sample < lo_q) begin
						lo_q <= rd_sample;
					end
				end
				if (!scan_issue && !rd_vld_s1) begin
					quo_q <= sum_mag;
					rem_q <= '0;
					neg_q <= sum_q[SUM_W-1];
				end
			end
			ST_DIV: begin
				rem_q <= trial_fits ? trial_diff[CNT_W-1:0] : trial_shift[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], trial_fits};
			end
			ST_DONE: begin
				if (rsp_load) begin
					rsp_q.average <= avg_full[DATA_W-1:0];
					rsp_q.maximum <= hi_q;
					rsp_q.minimum <= lo_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
